>>> rtl/core/sseg_pkg.sv
`default_nettype none

package sseg_pkg;

   localparam int DIGIT_WIDTH   = 3;
   localparam int CODE_WIDTH    = 8;
   localparam int SEG_WIDTH     = 3;
   localparam int GLYPH_WIDTH   = 5;
   localparam int LIST_DEPTH    = 8;
   localparam int INDEX_WIDTH   = 3;

   localparam logic [SEG_WIDTH-1:0] SEG_A  = 3'h3;
   localparam logic [SEG_WIDTH-1:0] SEG_B  = 3'h1;
   localparam logic [SEG_WIDTH-1:0] SEG_C  = 3'h2;
   localparam logic [SEG_WIDTH-1:0] SEG_D  = 3'h5;
   localparam logic [SEG_WIDTH-1:0] SEG_E  = 3'h7;
   localparam logic [SEG_WIDTH-1:0] SEG_F  = 3'h4;
   localparam logic [SEG_WIDTH-1:0] SEG_G  = 3'h6;
   localparam logic [SEG_WIDTH-1:0] SEG_DP = 3'h0;

   localparam logic [GLYPH_WIDTH-1:0] GLYPH_MODULUS = 5'd17;
   localparam logic [GLYPH_WIDTH-1:0] GLYPH_POINT   = 5'd16;

   // entry 0 is emitted first; unused entries hold the point address
   typedef logic [LIST_DEPTH-1:0][SEG_WIDTH-1:0] seg_list_type;

   typedef struct packed {
      logic [INDEX_WIDTH-1:0] last_index;
      seg_list_type           segs;
   } glyph_type;

   typedef struct packed {
      logic load;
      logic advance;
   } ctrl_cmd_type;

   typedef struct packed {
      logic digit_ok;
      logic last;
   } ctrl_status_type;

   // 16 = -1 mod 17, so code mod 17 = low nibble - high nibble, wrapped
   function automatic logic [GLYPH_WIDTH-1:0] code_to_glyph(
      input logic [CODE_WIDTH-1:0] code
   );
      logic [GLYPH_WIDTH-1:0] lo;
      logic [GLYPH_WIDTH-1:0] hi;
      lo = {1'b0, code[3:0]};
      hi = {1'b0, code[7:4]};
      if (lo >= hi) begin
         return lo - hi;
      end else begin
         return lo + GLYPH_MODULUS - hi;
      end
   endfunction

   // last_index counts the appended point when point is set, unless the glyph is the point
   function automatic glyph_type glyph_lookup(
      input logic [GLYPH_WIDTH-1:0] glyph,
      input logic                   point
   );
      glyph_type g;
      logic [INDEX_WIDTH-1:0] count_m1;
      logic                   append;
      g.segs   = '{default: SEG_DP};
      count_m1 = '0;
      case (glyph)
         5'd0: begin
            g.segs[5:0] = {SEG_F, SEG_E, SEG_D, SEG_C, SEG_B, SEG_A};
            count_m1 = 3'd5;
         end
         5'd1: begin
            g.segs[1:0] = {SEG_C, SEG_B};
            count_m1 = 3'd1;
         end
         5'd2: begin
            g.segs[4:0] = {SEG_G, SEG_E, SEG_D, SEG_B, SEG_A};
            count_m1 = 3'd4;
         end
         5'd3: begin
            g.segs[4:0] = {SEG_G, SEG_D, SEG_C, SEG_B, SEG_A};
            count_m1 = 3'd4;
         end
         5'd4: begin
            g.segs[3:0] = {SEG_G, SEG_F, SEG_C, SEG_B};
            count_m1 = 3'd3;
         end
         5'd5: begin
            g.segs[4:0] = {SEG_G, SEG_F, SEG_D, SEG_C, SEG_A};
            count_m1 = 3'd4;
         end
         5'd6: begin
            g.segs[5:0] = {SEG_G, SEG_F, SEG_E, SEG_D, SEG_C, SEG_A};
            count_m1 = 3'd5;
         end
         5'd7: begin
            g.segs[2:0] = {SEG_C, SEG_B, SEG_A};
            count_m1 = 3'd2;
         end
         5'd8: begin
            g.segs[6:0] = {SEG_G, SEG_F, SEG_E, SEG_D, SEG_C, SEG_B, SEG_A};
            count_m1 = 3'd6;
         end
         5'd9: begin
            g.segs[5:0] = {SEG_G, SEG_F, SEG_D, SEG_C, SEG_B, SEG_A};
            count_m1 = 3'd5;
         end
         5'd10: begin
            g.segs[5:0] = {SEG_G, SEG_F, SEG_E, SEG_C, SEG_B, SEG_A};
            count_m1 = 3'd5;
         end
         5'd11: begin
            g.segs[4:0] = {SEG_G, SEG_F, SEG_E, SEG_D, SEG_C};
            count_m1 = 3'd4;
         end
         5'd12: begin
            g.segs[3:0] = {SEG_F, SEG_E, SEG_D, SEG_A};
            count_m1 = 3'd3;
         end
         5'd13: begin
            g.segs[4:0] = {SEG_G, SEG_E, SEG_D, SEG_C, SEG_B};
            count_m1 = 3'd4;
         end
         5'd14: begin
            g.segs[4:0] = {SEG_G, SEG_F, SEG_E, SEG_D, SEG_A};
            count_m1 = 3'd4;
         end
         5'd15: begin
            g.segs[3:0] = {SEG_G, SEG_F, SEG_E, SEG_A};
            count_m1 = 3'd3;
         end
         default: begin
            g.segs[0] = SEG_DP;
            count_m1 = 3'd0;
         end
      endcase
      append       = point && (glyph != GLYPH_POINT);
      g.last_index = count_m1 + {2'b00, append};
      return g;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/seven_segment_scan_sequencer_top.sv
// The first segment result is registered and valid the cycle after the request is taken.
// One result per cycle while rsp_stall is low, 1 to 8 per request; the next request
// can be taken in the same cycle as the last result of the one before it is taken.
// The segment list register and its index counter set this rate.
// A request for a digit at or above NUM_DIGITS is taken and gives no result.
// Reset (synchronous, active high) returns the controller to idle.
`default_nettype none

module seven_segment_scan_sequencer_top #(
   parameter int NUM_DIGITS = 6
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic [sseg_pkg::DIGIT_WIDTH-1:0]     req_digit_select,
   input  wire logic [sseg_pkg::CODE_WIDTH-1:0]      req_char_code,
   input  wire logic                                 req_show_point,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic [sseg_pkg::DIGIT_WIDTH-1:0]          rsp_digit_out,
   output logic [sseg_pkg::SEG_WIDTH-1:0]            rsp_segment_address,
   output logic                                      rsp_last_segment
);

   sseg_pkg::ctrl_cmd_type    cmd;
   sseg_pkg::ctrl_status_type status;

   sseg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   sseg_dpath #(
      .NUM_DIGITS (NUM_DIGITS)
   ) u_dpath (
      .clock               (clock),
      .req_digit_select    (req_digit_select),
      .req_char_code       (req_char_code),
      .req_show_point      (req_show_point),
      .cmd                 (cmd),
      .status              (status),
      .rsp_digit_out       (rsp_digit_out),
      .rsp_segment_address (rsp_segment_address),
      .rsp_last_segment    (rsp_last_segment)
   );

endmodule

`default_nettype wire

>>> rtl/core/sseg_ctrl.sv
`default_nettype none

module sseg_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   input  wire sseg_pkg::ctrl_status_type status,
   output sseg_pkg::ctrl_cmd_type        cmd
);

   localparam logic STATE_IDLE = 1'b0;
   localparam logic STATE_EMIT = 1'b1;

   logic state_ff;
   logic state_in;
   logic rsp_take;
   logic done;
   logic req_take;

   assign rsp_valid   = (state_ff == STATE_EMIT);
   assign rsp_take    = rsp_valid && !rsp_stall;
   assign done        = rsp_take && status.last;
   assign req_stall   = rsp_valid && !done;
   assign req_take    = req_valid && !req_stall;
   assign cmd.load    = req_take && status.digit_ok;
   assign cmd.advance = rsp_take && !status.last;

   always_comb begin
      state_in = state_ff;
      if (cmd.load) begin
         state_in = STATE_EMIT;
      end else if (done) begin
         state_in = STATE_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/sseg_dpath.sv
`default_nettype none

module sseg_dpath #(
   parameter int NUM_DIGITS = 6
) (
   input  wire logic                                 clock,
   input  wire logic [sseg_pkg::DIGIT_WIDTH-1:0]     req_digit_select,
   input  wire logic [sseg_pkg::CODE_WIDTH-1:0]      req_char_code,
   input  wire logic                                 req_show_point,
   input  wire sseg_pkg::ctrl_cmd_type               cmd,
   output sseg_pkg::ctrl_status_type                 status,
   output logic [sseg_pkg::DIGIT_WIDTH-1:0]          rsp_digit_out,
   output logic [sseg_pkg::SEG_WIDTH-1:0]            rsp_segment_address,
   output logic                                      rsp_last_segment
);

   logic [sseg_pkg::DIGIT_WIDTH-1:0] digit_ff;
   sseg_pkg::seg_list_type           segs_ff;
   logic [sseg_pkg::INDEX_WIDTH-1:0] last_index_ff;
   logic [sseg_pkg::INDEX_WIDTH-1:0] index_ff;
   sseg_pkg::glyph_type              glyph;

   assign glyph = sseg_pkg::glyph_lookup(sseg_pkg::code_to_glyph(req_char_code),
                                         req_show_point);

   assign status.digit_ok = ({1'b0, req_digit_select}
                             < (sseg_pkg::DIGIT_WIDTH + 1)'(NUM_DIGITS));
   assign status.last     = (index_ff == last_index_ff);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         digit_ff      <= req_digit_select;
         segs_ff       <= glyph.segs;
         last_index_ff <= glyph.last_index;
         index_ff      <= '0;
      end else if (cmd.advance) begin
         index_ff <= index_ff + 1'b1;
      end
   end

   assign rsp_digit_out       = digit_ff;
   assign rsp_segment_address = segs_ff[index_ff];
   assign rsp_last_segment    = status.last;

endmodule

`default_nettype wire

>>> rtl/core/sseg_checker.sv
`default_nettype none

module sseg_checker #(
   parameter int NUM_DIGITS = 6
) (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_valid,
   input wire logic                             req_stall,
   input wire logic [sseg_pkg::DIGIT_WIDTH-1:0] req_digit_select,
   input wire logic                             rsp_valid,
   input wire logic                             rsp_stall,
   input wire logic [sseg_pkg::DIGIT_WIDTH-1:0] rsp_digit_out,
   input wire logic [sseg_pkg::SEG_WIDTH-1:0]   rsp_segment_address,
   input wire logic                             rsp_last_segment
);

   logic req_take;
   logic rsp_take;
   logic bad_digit;

   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid && !rsp_stall;
   assign bad_digit = ({1'b0, req_digit_select}
                       >= (sseg_pkg::DIGIT_WIDTH + 1)'(NUM_DIGITS));

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_digit_out)
         && $stable(rsp_segment_address) && $stable(rsp_last_segment))
      else $error("stalled result changed");

   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_take && !rsp_last_segment |=> rsp_valid && $stable(rsp_digit_out))
      else $error("segment sequence broken");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !(rsp_take && rsp_last_segment) |-> req_stall)
      else $error("request taken before results finished");

   a_bad_digit_silent: assert property (@(posedge clock) disable iff (reset)
      req_take && bad_digit |=> !rsp_valid)
      else $error("result for out-of-range digit");

   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, rsp_digit_out}
                     < (sseg_pkg::DIGIT_WIDTH + 1)'(NUM_DIGITS)))
      else $error("digit out of range");

endmodule

bind seven_segment_scan_sequencer_top sseg_checker #(
   .NUM_DIGITS (NUM_DIGITS)
) u_sseg_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_stall           (req_stall),
   .req_digit_select    (req_digit_select),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_digit_out       (rsp_digit_out),
   .rsp_segment_address (rsp_segment_address),
   .rsp_last_segment    (rsp_last_segment)
);

`default_nettype wire
